/* hdl/spcs_pkg.sv */
package spcs_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CMD_W         = 2;
    localparam int ROT_W         = 18;
    localparam int TSTEP_W       = 17;
    localparam int COEF_W        = 31;
    localparam int SEL_W         = 6;
    localparam int OP_W          = 3;
    localparam int RF_DEPTH      = 32;
    localparam int RF_AW         = $clog2(RF_DEPTH);

    localparam logic [CMD_W-1:0] CMD_PREPARE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WARM    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TSTEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HZ     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMASS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IINERT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INERT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AX     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AY     = 3'd7;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_NEG = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV = 3'd4;

    // register file slots: persistent state first, then scratch
    localparam logic [SEL_W-1:0] R_BIAS  = 6'd0;
    localparam logic [SEL_W-1:0] R_IMPC  = 6'd1;
    localparam logic [SEL_W-1:0] R_MASSC = 6'd2;
    localparam logic [SEL_W-1:0] R_EM0   = 6'd3;
    localparam logic [SEL_W-1:0] R_EM1   = 6'd4;
    localparam logic [SEL_W-1:0] R_EM2   = 6'd5;
    localparam logic [SEL_W-1:0] R_SS0   = 6'd6;
    localparam logic [SEL_W-1:0] R_SS1   = 6'd7;
    localparam logic [SEL_W-1:0] R_AI0   = 6'd8;
    localparam logic [SEL_W-1:0] R_AI1   = 6'd9;
    localparam logic [SEL_W-1:0] R_AM    = 6'd10;
    localparam logic [SEL_W-1:0] R_RX    = 6'd11;
    localparam logic [SEL_W-1:0] R_RY    = 6'd12;
    localparam logic [SEL_W-1:0] R_T13   = 6'd13;
    localparam logic [SEL_W-1:0] R_T14   = 6'd14;
    localparam logic [SEL_W-1:0] R_T15   = 6'd15;
    localparam logic [SEL_W-1:0] R_T16   = 6'd16;
    localparam logic [SEL_W-1:0] R_T17   = 6'd17;
    localparam logic [SEL_W-1:0] R_T18   = 6'd18;
    localparam logic [SEL_W-1:0] R_T19   = 6'd19;
    localparam logic [SEL_W-1:0] R_T20   = 6'd20;
    localparam logic [SEL_W-1:0] R_T21   = 6'd21;
    localparam logic [SEL_W-1:0] R_T22   = 6'd22;
    localparam logic [SEL_W-1:0] R_T23   = 6'd23;
    localparam logic [SEL_W-1:0] R_T24   = 6'd24;
    localparam logic [SEL_W-1:0] R_T25   = 6'd25;
    localparam logic [SEL_W-1:0] R_T26   = 6'd26;
    localparam logic [SEL_W-1:0] R_T27   = 6'd27;
    localparam logic [SEL_W-1:0] R_T28   = 6'd28;
    localparam logic [SEL_W-1:0] R_T29   = 6'd29;

    // operand sources outside the register file
    localparam logic [SEL_W-1:0] S_ZERO   = 6'd32;
    localparam logic [SEL_W-1:0] S_ONE    = 6'd33;
    localparam logic [SEL_W-1:0] S_TWO_PI = 6'd34;
    localparam logic [SEL_W-1:0] S_PI     = 6'd35;
    localparam logic [SEL_W-1:0] S_MZETA  = 6'd36;
    localparam logic [SEL_W-1:0] S_TSTEP  = 6'd37;
    localparam logic [SEL_W-1:0] S_HZ     = 6'd38;
    localparam logic [SEL_W-1:0] S_DAMP   = 6'd39;
    localparam logic [SEL_W-1:0] S_IMASS  = 6'd40;
    localparam logic [SEL_W-1:0] S_IINERT = 6'd41;
    localparam logic [SEL_W-1:0] S_INERT  = 6'd42;
    localparam logic [SEL_W-1:0] S_AX     = 6'd43;
    localparam logic [SEL_W-1:0] S_AY     = 6'd44;
    localparam logic [SEL_W-1:0] S_RC     = 6'd45;
    localparam logic [SEL_W-1:0] S_RS     = 6'd46;
    localparam logic [SEL_W-1:0] S_CX     = 6'd47;
    localparam logic [SEL_W-1:0] S_CY     = 6'd48;
    localparam logic [SEL_W-1:0] S_TX     = 6'd49;
    localparam logic [SEL_W-1:0] S_TY     = 6'd50;
    localparam logic [SEL_W-1:0] S_VX     = 6'd51;
    localparam logic [SEL_W-1:0] S_VY     = 6'd52;
    localparam logic [SEL_W-1:0] S_W      = 6'd53;
    localparam logic [SEL_W-1:0] S_DX     = 6'd54;
    localparam logic [SEL_W-1:0] S_DY     = 6'd55;

    // destinations outside the register file
    localparam logic [SEL_W-1:0] D_OVX = 6'd32;
    localparam logic [SEL_W-1:0] D_OVY = 6'd33;
    localparam logic [SEL_W-1:0] D_OW  = 6'd34;

    localparam int PRO_LEN   = 6;
    localparam int PREP_LEN  = 30;
    localparam int WARM_LEN  = 10;
    localparam int SOLVE_LEN = 51;
    localparam int NOP_LEN   = 3;
    localparam int A_PREP    = 0;
    localparam int A_WARM    = A_PREP + PRO_LEN + PREP_LEN;
    localparam int A_SOLVE   = A_WARM + PRO_LEN + WARM_LEN;
    localparam int A_NOP     = A_SOLVE + PRO_LEN + SOLVE_LEN;
    localparam int UC_DEPTH  = A_NOP + NOP_LEN;
    localparam int PC_W      = $clog2(UC_DEPTH);

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SEL_W-1:0] a;
        logic [SEL_W-1:0] b;
        logic [SEL_W-1:0] d;
        logic             last;
    } uop_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DATA_W-1:0] quot;
        logic                     clamp;
    } div_rsp_t;

    function automatic uop_t mi(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] a,
                                input logic [SEL_W-1:0] b, input logic [SEL_W-1:0] d,
                                input logic last);
        uop_t u;
        u.op   = op;
        u.a    = a;
        u.b    = b;
        u.d    = d;
        u.last = last;
        return u;
    endfunction

    // world-frame anchor arm rx, ry
    function automatic uop_t uc_pro(input pc_t k);
        uop_t u;
        case (k)
            7'd0:    u = mi(OP_MUL, S_RC,  S_AX,  R_T13, 1'b0);
            7'd1:    u = mi(OP_MUL, S_RS,  S_AY,  R_T14, 1'b0);
            7'd2:    u = mi(OP_SUB, R_T13, R_T14, R_RX,  1'b0);
            7'd3:    u = mi(OP_MUL, S_RS,  S_AX,  R_T13, 1'b0);
            7'd4:    u = mi(OP_MUL, S_RC,  S_AY,  R_T14, 1'b0);
            7'd5:    u = mi(OP_ADD, R_T13, R_T14, R_RY,  1'b0);
            default: u = mi(OP_ADD, S_ZERO, S_ZERO, R_T13, 1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t uc_prep(input pc_t k);
        uop_t u;
        case (k)
            7'd0:    u = mi(OP_MUL, S_TWO_PI, S_HZ,  R_T15,   1'b0);
            7'd1:    u = mi(OP_ADD, S_DAMP,   S_DAMP, R_T16,  1'b0);
            7'd2:    u = mi(OP_MUL, S_TSTEP,  R_T15, R_T17,   1'b0);
            7'd3:    u = mi(OP_ADD, R_T16,    R_T17, R_T18,   1'b0);
            7'd4:    u = mi(OP_MUL, R_T17,    R_T18, R_T19,   1'b0);
            7'd5:    u = mi(OP_ADD, S_ONE,    R_T19, R_T20,   1'b0);
            7'd6:    u = mi(OP_DIV, S_ONE,    R_T20, R_IMPC,  1'b0);
            7'd7:    u = mi(OP_MUL, R_T19,    R_IMPC, R_MASSC, 1'b0);
            7'd8:    u = mi(OP_DIV, R_T15,    R_T18, R_BIAS,  1'b0);
            7'd9:    u = mi(OP_MUL, S_IINERT, R_RY,  R_T13,   1'b0);
            7'd10:   u = mi(OP_MUL, R_T13,    R_RY,  R_T13,   1'b0);
            7'd11:   u = mi(OP_ADD, S_IMASS,  R_T13, R_T21,   1'b0);
            7'd12:   u = mi(OP_MUL, S_IINERT, R_RX,  R_T13,   1'b0);
            7'd13:   u = mi(OP_MUL, R_T13,    R_RY,  R_T13,   1'b0);
            7'd14:   u = mi(OP_NEG, R_T13,    S_ZERO, R_T22,  1'b0);
            7'd15:   u = mi(OP_MUL, S_IINERT, R_RX,  R_T13,   1'b0);
            7'd16:   u = mi(OP_MUL, R_T13,    R_RX,  R_T13,   1'b0);
            7'd17:   u = mi(OP_ADD, S_IMASS,  R_T13, R_T23,   1'b0);
            7'd18:   u = mi(OP_MUL, R_T21,    R_T23, R_T13,   1'b0);
            7'd19:   u = mi(OP_MUL, R_T22,    R_T22, R_T14,   1'b0);
            7'd20:   u = mi(OP_SUB, R_T13,    R_T14, R_T24,   1'b0);
            7'd21:   u = mi(OP_DIV, R_T23,    R_T24, R_EM0,   1'b0);
            7'd22:   u = mi(OP_NEG, R_T22,    S_ZERO, R_T13,  1'b0);
            7'd23:   u = mi(OP_DIV, R_T13,    R_T24, R_EM1,   1'b0);
            7'd24:   u = mi(OP_DIV, R_T21,    R_T24, R_EM2,   1'b0);
            7'd25:   u = mi(OP_SUB, S_CX,     S_TX,  R_SS0,   1'b0);
            7'd26:   u = mi(OP_SUB, S_CY,     S_TY,  R_SS1,   1'b0);
            7'd27:   u = mi(OP_ADD, S_VX,     S_ZERO, D_OVX,  1'b0);
            7'd28:   u = mi(OP_ADD, S_VY,     S_ZERO, D_OVY,  1'b0);
            7'd29:   u = mi(OP_ADD, S_W,      S_ZERO, D_OW,   1'b1);
            default: u = mi(OP_ADD, S_ZERO,   S_ZERO, R_T13,  1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t uc_warm(input pc_t k);
        uop_t u;
        case (k)
            7'd0:    u = mi(OP_MUL, R_RX,     R_AI1, R_T13, 1'b0);
            7'd1:    u = mi(OP_MUL, R_RY,     R_AI0, R_T14, 1'b0);
            7'd2:    u = mi(OP_SUB, R_T13,    R_T14, R_T15, 1'b0);
            7'd3:    u = mi(OP_MUL, S_IMASS,  R_AI0, R_T13, 1'b0);
            7'd4:    u = mi(OP_ADD, S_VX,     R_T13, D_OVX, 1'b0);
            7'd5:    u = mi(OP_MUL, S_IMASS,  R_AI1, R_T13, 1'b0);
            7'd6:    u = mi(OP_ADD, S_VY,     R_T13, D_OVY, 1'b0);
            7'd7:    u = mi(OP_ADD, R_T15,    R_AM,  R_T13, 1'b0);
            7'd8:    u = mi(OP_MUL, S_IINERT, R_T13, R_T13, 1'b0);
            7'd9:    u = mi(OP_ADD, S_W,      R_T13, D_OW,  1'b1);
            default: u = mi(OP_ADD, S_ZERO,   S_ZERO, R_T13, 1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t uc_solve(input pc_t k);
        uop_t u;
        case (k)
            // motor damping
            7'd0:    u = mi(OP_MUL, S_TSTEP,  S_PI,   R_T15, 1'b0);
            7'd1:    u = mi(OP_ADD, S_MZETA,  R_T15,  R_T16, 1'b0);
            7'd2:    u = mi(OP_MUL, R_T15,    R_T16,  R_T17, 1'b0);
            7'd3:    u = mi(OP_ADD, S_ONE,    R_T17,  R_T18, 1'b0);
            7'd4:    u = mi(OP_DIV, S_ONE,    R_T18,  R_T19, 1'b0);
            7'd5:    u = mi(OP_MUL, R_T17,    R_T19,  R_T20, 1'b0);
            7'd6:    u = mi(OP_MUL, R_T20,    S_INERT, R_T13, 1'b0);
            7'd7:    u = mi(OP_MUL, R_T13,    S_W,    R_T13, 1'b0);
            7'd8:    u = mi(OP_NEG, R_T13,    S_ZERO, R_T13, 1'b0);
            7'd9:    u = mi(OP_MUL, R_T19,    R_AM,   R_T14, 1'b0);
            7'd10:   u = mi(OP_SUB, R_T13,    R_T14,  R_T14, 1'b0);
            7'd11:   u = mi(OP_ADD, R_AM,     R_T14,  R_AM,  1'b0);
            7'd12:   u = mi(OP_MUL, S_IINERT, R_T14,  R_T13, 1'b0);
            7'd13:   u = mi(OP_ADD, S_W,      R_T13,  R_T21, 1'b0);
            // point constraint
            7'd14:   u = mi(OP_MUL, R_T21,    R_RY,   R_T13, 1'b0);
            7'd15:   u = mi(OP_SUB, S_VX,     R_T13,  R_T22, 1'b0);
            7'd16:   u = mi(OP_MUL, R_T21,    R_RX,   R_T13, 1'b0);
            7'd17:   u = mi(OP_ADD, S_VY,     R_T13,  R_T23, 1'b0);
            7'd18:   u = mi(OP_ADD, S_DX,     R_RX,   R_T13, 1'b0);
            7'd19:   u = mi(OP_ADD, R_T13,    R_SS0,  R_T13, 1'b0);
            7'd20:   u = mi(OP_MUL, R_BIAS,   R_T13,  R_T13, 1'b0);
            7'd21:   u = mi(OP_ADD, R_T22,    R_T13,  R_T24, 1'b0);
            7'd22:   u = mi(OP_ADD, S_DY,     R_RY,   R_T13, 1'b0);
            7'd23:   u = mi(OP_ADD, R_T13,    R_SS1,  R_T13, 1'b0);
            7'd24:   u = mi(OP_MUL, R_BIAS,   R_T13,  R_T13, 1'b0);
            7'd25:   u = mi(OP_ADD, R_T23,    R_T13,  R_T25, 1'b0);
            7'd26:   u = mi(OP_MUL, R_EM0,    R_T24,  R_T13, 1'b0);
            7'd27:   u = mi(OP_MUL, R_EM1,    R_T25,  R_T14, 1'b0);
            7'd28:   u = mi(OP_ADD, R_T13,    R_T14,  R_T26, 1'b0);
            7'd29:   u = mi(OP_MUL, R_EM1,    R_T24,  R_T13, 1'b0);
            7'd30:   u = mi(OP_MUL, R_EM2,    R_T25,  R_T14, 1'b0);
            7'd31:   u = mi(OP_ADD, R_T13,    R_T14,  R_T27, 1'b0);
            7'd32:   u = mi(OP_MUL, R_MASSC,  R_T26,  R_T13, 1'b0);
            7'd33:   u = mi(OP_NEG, R_T13,    S_ZERO, R_T13, 1'b0);
            7'd34:   u = mi(OP_MUL, R_IMPC,   R_AI0,  R_T14, 1'b0);
            7'd35:   u = mi(OP_SUB, R_T13,    R_T14,  R_T28, 1'b0);
            7'd36:   u = mi(OP_MUL, R_MASSC,  R_T27,  R_T13, 1'b0);
            7'd37:   u = mi(OP_NEG, R_T13,    S_ZERO, R_T13, 1'b0);
            7'd38:   u = mi(OP_MUL, R_IMPC,   R_AI1,  R_T14, 1'b0);
            7'd39:   u = mi(OP_SUB, R_T13,    R_T14,  R_T29, 1'b0);
            7'd40:   u = mi(OP_ADD, R_AI0,    R_T28,  R_AI0, 1'b0);
            7'd41:   u = mi(OP_ADD, R_AI1,    R_T29,  R_AI1, 1'b0);
            7'd42:   u = mi(OP_MUL, S_IMASS,  R_T28,  R_T13, 1'b0);
            7'd43:   u = mi(OP_ADD, S_VX,     R_T13,  D_OVX, 1'b0);
            7'd44:   u = mi(OP_MUL, S_IMASS,  R_T29,  R_T13, 1'b0);
            7'd45:   u = mi(OP_ADD, S_VY,     R_T13,  D_OVY, 1'b0);
            7'd46:   u = mi(OP_MUL, R_RX,     R_T29,  R_T13, 1'b0);
            7'd47:   u = mi(OP_MUL, R_RY,     R_T28,  R_T14, 1'b0);
            7'd48:   u = mi(OP_SUB, R_T13,    R_T14,  R_T13, 1'b0);
            7'd49:   u = mi(OP_MUL, S_IINERT, R_T13,  R_T13, 1'b0);
            7'd50:   u = mi(OP_ADD, R_T21,    R_T13,  D_OW,  1'b1);
            default: u = mi(OP_ADD, S_ZERO,   S_ZERO, R_T13, 1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t uc_nop(input pc_t k);
        uop_t u;
        case (k)
            7'd0:    u = mi(OP_ADD, S_VX,   S_ZERO, D_OVX, 1'b0);
            7'd1:    u = mi(OP_ADD, S_VY,   S_ZERO, D_OVY, 1'b0);
            7'd2:    u = mi(OP_ADD, S_W,    S_ZERO, D_OW,  1'b1);
            default: u = mi(OP_ADD, S_ZERO, S_ZERO, R_T13, 1'b1);
        endcase
        return u;
    endfunction

    // microcode store: arm prologue then body, except CMD_NONE: body only
    function automatic uop_t ucode(input pc_t pc);
        uop_t u;
        if (pc < PC_W'(A_WARM)) begin
            if (pc < PC_W'(A_PREP + PRO_LEN))
                u = uc_pro(pc - PC_W'(A_PREP));
            else
                u = uc_prep(pc - PC_W'(A_PREP + PRO_LEN));
        end else if (pc < PC_W'(A_SOLVE)) begin
            if (pc < PC_W'(A_WARM + PRO_LEN))
                u = uc_pro(pc - PC_W'(A_WARM));
            else
                u = uc_warm(pc - PC_W'(A_WARM + PRO_LEN));
        end else if (pc < PC_W'(A_NOP)) begin
            if (pc < PC_W'(A_SOLVE + PRO_LEN))
                u = uc_pro(pc - PC_W'(A_SOLVE));
            else
                u = uc_solve(pc - PC_W'(A_SOLVE + PRO_LEN));
        end else begin
            u = uc_nop(pc - PC_W'(A_NOP));
        end
        return u;
    endfunction

endpackage

/* hdl/spcs_if.sv */
interface spcs_req_if import spcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [ROT_W-1:0]  rot_cos;
    logic signed [ROT_W-1:0]  rot_sin;
    logic signed [DATA_W-1:0] centre_x;
    logic signed [DATA_W-1:0] centre_y;
    logic signed [DATA_W-1:0] target_x;
    logic signed [DATA_W-1:0] target_y;
    logic signed [DATA_W-1:0] lin_vel_x;
    logic signed [DATA_W-1:0] lin_vel_y;
    logic signed [DATA_W-1:0] ang_vel;
    logic signed [DATA_W-1:0] delta_x;
    logic signed [DATA_W-1:0] delta_y;

    modport source (output valid, command, rot_cos, rot_sin, centre_x, centre_y,
                    target_x, target_y, lin_vel_x, lin_vel_y, ang_vel, delta_x, delta_y,
                    input ready);
    modport sink (input valid, command, rot_cos, rot_sin, centre_x, centre_y,
                  target_x, target_y, lin_vel_x, lin_vel_y, ang_vel, delta_x, delta_y,
                  output ready);
endinterface

interface spcs_rsp_if import spcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic signed [DATA_W-1:0] new_ang_vel;
    logic                     saturated;

    modport source (output valid, new_vel_x, new_vel_y, new_ang_vel, saturated,
                    input ready);
    modport sink (input valid, new_vel_x, new_vel_y, new_ang_vel, saturated,
                  output ready);
endinterface

/* hdl/soft_point_constraint_solver_unit.sv */
// Soft point-to-target constraint of one 2D body, Q16.16 fixed point.
// Request channel req carries one word per command: prepare, warm start or
// solve, with rotation, centre, target, velocity and position change.
// Response channel rsp returns one word per request: the new linear and
// angular velocity and a flag set when any value of that command clamped.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// only while the block is idle, a rule for the user that the block itself
// does not enforce; writes take effect on the next request. Each request
// runs a microprogram on one shared multiply/add unit: each micro-operation
// has an operand read and an execute step, and each divide then waits for
// the bit-serial divider. Prepare runs five divides, solve one, warm start
// and the unused command none; the response is posted at the same edge at
// which req.ready rises again.
// A finished word waits in the response register while the next request is
// accepted; if the receiver stalls, a later result holds until it is taken.
// Reset (rst_n, asynchronous) clears the stored coefficients, effective mass,
// start separation and accumulated impulses to zero and restores the
// configuration defaults.
module soft_point_constraint_solver_unit
    import spcs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    spcs_req_if.sink             req,
    spcs_rsp_if.source           rsp
);

    localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] PI_Q     = (PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic [63:0] TWO_PI_Q = (2 * PI_Q30 + (64'd1 << (29 - FRAC_BITS)))
                                       >> (30 - FRAC_BITS);
    localparam logic [63:0] MZETA_Q  = (2 * ONE_Q + 5) / 10;
    localparam logic signed [65:0] HALF_Q = 66'sd1 <<< (FRAC_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_DIVW = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // configuration
    logic [TSTEP_W-1:0]       tstep_reg;
    logic [COEF_W-1:0]        hz_reg;
    logic [COEF_W-1:0]        damp_reg;
    logic [COEF_W-1:0]        imass_reg;
    logic [COEF_W-1:0]        iinert_reg;
    logic [COEF_W-1:0]        inert_reg;
    logic signed [DATA_W-1:0] ax_reg;
    logic signed [DATA_W-1:0] ay_reg;

    // captured request word
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [ROT_W-1:0]  rc_reg;
    logic signed [ROT_W-1:0]  rs_reg;
    logic signed [DATA_W-1:0] cx_reg;
    logic signed [DATA_W-1:0] cy_reg;
    logic signed [DATA_W-1:0] tx_reg;
    logic signed [DATA_W-1:0] ty_reg;
    logic signed [DATA_W-1:0] vx_reg;
    logic signed [DATA_W-1:0] vy_reg;
    logic signed [DATA_W-1:0] w_reg;
    logic signed [DATA_W-1:0] dx_reg;
    logic signed [DATA_W-1:0] dy_reg;

    // sequencer and datapath
    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    pc_t                      pc_reg;
    pc_t                      pc_next;
    uop_t                     uop;
    logic signed [DATA_W-1:0] op_a_reg;
    logic signed [DATA_W-1:0] op_b_reg;
    logic signed [DATA_W-1:0] src_a;
    logic signed [DATA_W-1:0] src_b;
    logic                     sat_reg;

    // register file: persistent state and scratch, invalid slots read as zero
    logic signed [DATA_W-1:0] rf_reg [RF_DEPTH];
    logic [RF_DEPTH-1:0]      rf_vld_reg;

    // staged and delivered results
    logic signed [DATA_W-1:0] ovx_reg;
    logic signed [DATA_W-1:0] ovy_reg;
    logic signed [DATA_W-1:0] ow_reg;
    logic signed [DATA_W-1:0] res_vx_reg;
    logic signed [DATA_W-1:0] res_vy_reg;
    logic signed [DATA_W-1:0] res_w_reg;
    logic                     res_sat_reg;
    logic                     out_vld_reg;

    logic signed [63:0]       prod;
    logic signed [65:0]       alu_wide;
    logic signed [DATA_W-1:0] alu_val;
    logic                     alu_clamp;
    logic                     wb_en;
    logic signed [DATA_W-1:0] wb_val;
    logic                     wb_clamp;
    logic                     out_load;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    function automatic logic signed [DATA_W-1:0] sel_src(
        input logic [SEL_W-1:0] sel,
        input logic [RF_DEPTH-1:0] vld,
        input logic signed [DATA_W-1:0] rf_word
    );
        logic signed [DATA_W-1:0] v;
        if (!sel[SEL_W-1])
        begin
            v = vld[sel[RF_AW-1:0]] ? rf_word : '0;
        end
        else
        begin
            case (sel)
                S_ZERO:   v = '0;
                S_ONE:    v = ONE_Q[DATA_W-1:0];
                S_TWO_PI: v = TWO_PI_Q[DATA_W-1:0];
                S_PI:     v = PI_Q[DATA_W-1:0];
                S_MZETA:  v = MZETA_Q[DATA_W-1:0];
                S_TSTEP:  v = DATA_W'(tstep_reg);
                S_HZ:     v = DATA_W'(hz_reg);
                S_DAMP:   v = DATA_W'(damp_reg);
                S_IMASS:  v = DATA_W'(imass_reg);
                S_IINERT: v = DATA_W'(iinert_reg);
                S_INERT:  v = DATA_W'(inert_reg);
                S_AX:     v = ax_reg;
                S_AY:     v = ay_reg;
                S_RC:     v = DATA_W'(rc_reg);
                S_RS:     v = DATA_W'(rs_reg);
                S_CX:     v = cx_reg;
                S_CY:     v = cy_reg;
                S_TX:     v = tx_reg;
                S_TY:     v = ty_reg;
                S_VX:     v = vx_reg;
                S_VY:     v = vy_reg;
                S_W:      v = w_reg;
                S_DX:     v = dx_reg;
                S_DY:     v = dy_reg;
                default:  v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic pc_t start_pc(input logic [CMD_W-1:0] cmd);
        pc_t p;
        case (cmd)
            CMD_PREPARE: p = PC_W'(A_PREP);
            CMD_WARM:    p = PC_W'(A_WARM);
            CMD_SOLVE:   p = PC_W'(A_SOLVE);
            CMD_NONE:    p = PC_W'(A_NOP);
            default:     p = PC_W'(A_NOP);
        endcase
        return p;
    endfunction

    assign uop   = ucode(pc_reg);
    assign src_a = sel_src(uop.a, rf_vld_reg, rf_reg[uop.a[RF_AW-1:0]]);
    assign src_b = sel_src(uop.b, rf_vld_reg, rf_reg[uop.b[RF_AW-1:0]]);

    // shared unit: product rounded to nearest with ties up, or a 33-bit sum
    always_comb
    begin
        prod = op_a_reg * op_b_reg;
        case (uop.op)
            OP_MUL:  alu_wide = ($signed({{2{prod[63]}}, prod}) + HALF_Q) >>> FRAC_BITS;
            OP_ADD:  alu_wide = 66'(op_a_reg) + 66'(op_b_reg);
            OP_SUB:  alu_wide = 66'(op_a_reg) - 66'(op_b_reg);
            OP_NEG:  alu_wide = 66'sd0 - 66'(op_a_reg);
            default: alu_wide = '0;
        endcase
        if (alu_wide > 66'sd2147483647)
        begin
            alu_val   = {1'b0, {(DATA_W-1){1'b1}}};
            alu_clamp = 1'b1;
        end
        else if (alu_wide < -66'sd2147483648)
        begin
            alu_val   = {1'b1, {(DATA_W-1){1'b0}}};
            alu_clamp = 1'b1;
        end
        else
        begin
            alu_val   = alu_wide[DATA_W-1:0];
            alu_clamp = 1'b0;
        end
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_EXEC) && (uop.op == OP_DIV);
        div_req.num   = op_a_reg;
        div_req.den   = op_b_reg;
    end

    spcs_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // write-back from the shared unit, or from the divider when it finishes
    always_comb
    begin
        wb_en    = 1'b0;
        wb_val   = alu_val;
        wb_clamp = alu_clamp;
        if ((state_reg == ST_EXEC) && (uop.op != OP_DIV))
        begin
            wb_en = 1'b1;
        end
        else if ((state_reg == ST_DIVW) && div_rsp.done)
        begin
            wb_en    = 1'b1;
            wb_val   = div_rsp.quot;
            wb_clamp = div_rsp.clamp;
        end
    end

    assign out_load = (state_reg == ST_FIN) && (!out_vld_reg || rsp.ready);

    // sequencer: fetch operands, execute, advance until the last micro-op
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_READ;
                    pc_next    = start_pc(req.command);
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (uop.op == OP_DIV)
                    state_next = ST_DIVW;
                else if (uop.last)
                    state_next = ST_FIN;
                else
                begin
                    state_next = ST_READ;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            ST_DIVW:
            begin
                if (div_rsp.done)
                begin
                    state_next = uop.last ? ST_FIN : ST_READ;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            rf_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
            tstep_reg   <= TSTEP_W'(1092);
            hz_reg      <= COEF_W'(327680);
            damp_reg    <= COEF_W'(65536);
            imass_reg   <= COEF_W'(65536);
            iinert_reg  <= COEF_W'(65536);
            inert_reg   <= COEF_W'(65536);
            ax_reg      <= '0;
            ay_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (wb_en && !uop.d[SEL_W-1])
                rf_vld_reg[uop.d[RF_AW-1:0]] <= 1'b1;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TSTEP:  tstep_reg  <= cfg_data[TSTEP_W-1:0];
                    CFG_HZ:     hz_reg     <= cfg_data[COEF_W-1:0];
                    CFG_DAMP:   damp_reg   <= cfg_data[COEF_W-1:0];
                    CFG_IMASS:  imass_reg  <= cfg_data[COEF_W-1:0];
                    CFG_IINERT: iinert_reg <= cfg_data[COEF_W-1:0];
                    CFG_INERT:  inert_reg  <= cfg_data[COEF_W-1:0];
                    CFG_AX:     ax_reg     <= cfg_data;
                    CFG_AY:     ay_reg     <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // payload: capture the word, fetch operands, write back, hold results
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req.valid)
        begin
            cmd_reg <= req.command;
            rc_reg  <= req.rot_cos;
            rs_reg  <= req.rot_sin;
            cx_reg  <= req.centre_x;
            cy_reg  <= req.centre_y;
            tx_reg  <= req.target_x;
            ty_reg  <= req.target_y;
            vx_reg  <= req.lin_vel_x;
            vy_reg  <= req.lin_vel_y;
            w_reg   <= req.ang_vel;
            dx_reg  <= req.delta_x;
            dy_reg  <= req.delta_y;
            sat_reg <= 1'b0;
        end
        else if (wb_en && wb_clamp && (cmd_reg != CMD_NONE))
        begin
            sat_reg <= 1'b1;
        end

        if (state_reg == ST_READ)
        begin
            op_a_reg <= src_a;
            op_b_reg <= src_b;
        end

        if (wb_en)
        begin
            if (!uop.d[SEL_W-1])
                rf_reg[uop.d[RF_AW-1:0]] <= wb_val;
            else if (uop.d == D_OVX)
                ovx_reg <= wb_val;
            else if (uop.d == D_OVY)
                ovy_reg <= wb_val;
            else if (uop.d == D_OW)
                ow_reg <= wb_val;
        end

        if (out_load)
        begin
            res_vx_reg  <= ovx_reg;
            res_vy_reg  <= ovy_reg;
            res_w_reg   <= ow_reg;
            res_sat_reg <= sat_reg;
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.new_vel_x   = res_vx_reg;
    assign rsp.new_vel_y   = res_vy_reg;
    assign rsp.new_ang_vel = res_w_reg;
    assign rsp.saturated   = res_sat_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_READ))
        else $error("accepted word did not start the microprogram");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIVW))
        else $error("divider finished while the sequencer was not waiting");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (rsp.valid && (state_reg == ST_IDLE)))
        else $error("finished result not posted to the response register");
`endif

endmodule

/* hdl/spcs_div.sv */
module spcs_div
    import spcs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int NW    = DATA_W + FRAC_BITS;
    localparam int QW    = NW + 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]     dvd_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] quot_reg;
    logic              clamp_reg;

    logic [DATA_W-1:0] abs_num;
    logic [DATA_W-1:0] abs_den;
    logic [QW-1:0]     dvd_init;
    logic [DATA_W:0]   rem_sh;
    logic              q_bit;
    logic [DATA_W:0]   rem_next;
    logic              pos_over;
    logic              neg_over;

    always_comb
    begin
        abs_num  = req.num[DATA_W-1] ? (DATA_W'(0) - req.num) : req.num;
        abs_den  = req.den[DATA_W-1] ? (DATA_W'(0) - req.den) : req.den;
        // round half away from zero on the magnitudes
        dvd_init = {1'b0, abs_num, {FRAC_BITS{1'b0}}} + QW'(abs_den >> 1);
        rem_sh   = {rem_reg[DATA_W-1:0], dvd_reg[QW-1]};
        q_bit    = (rem_sh >= {1'b0, dsr_reg});
        rem_next = q_bit ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
        pos_over = |dvd_reg[QW-1:DATA_W-1];
        neg_over = (|dvd_reg[QW-1:DATA_W]) || (dvd_reg[DATA_W-1] && (|dvd_reg[DATA_W-2:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(QW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg  <= dvd_init;
            rem_reg  <= '0;
            dsr_reg  <= abs_den;
            neg_reg  <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
            zero_reg <= (req.den == '0);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(QW))
            begin
                // saturate the signed quotient; a zero divisor gives zero
                if (zero_reg)
                begin
                    quot_reg  <= '0;
                    clamp_reg <= 1'b0;
                end
                else if (!neg_reg)
                begin
                    quot_reg  <= pos_over ? {1'b0, {(DATA_W-1){1'b1}}} : dvd_reg[DATA_W-1:0];
                    clamp_reg <= pos_over;
                end
                else
                begin
                    quot_reg  <= neg_over ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : (DATA_W'(0) - dvd_reg[DATA_W-1:0]);
                    clamp_reg <= neg_over;
                end
            end
            else
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[QW-2:0], q_bit};
            end
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.quot  = quot_reg;
    assign rsp.clamp = clamp_reg;

endmodule
